### src/hci_uart_packet_deframer_top_assert.svh
// Assertion macros for the H4 deframer, used by the output queue module.
// Every macro samples on clk_i and is switched off while rst_ni is low.
`ifndef HCI_UART_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define HCI_UART_PACKET_DEFRAMER_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define HCIDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define HCIDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

### src/hcidf_pkg.sv
// Types, constants and helper functions for the H4 HCI deframer.
// Used by the core, the output queue and the top level; depends on nothing.
package hcidf_pkg;

  // Packet kind, stored as the type byte minus one.
  typedef enum logic [1:0] {
    KIND_CMD,
    KIND_ACL,
    KIND_SCO,
    KIND_EVT
  } kind_e;

  // Valid range of the type byte.
  localparam logic [7:0] TYPE_FIRST = 8'h01;
  localparam logic [7:0] TYPE_LAST  = 8'h04;

  // Configuration register indexes.
  localparam logic CFG_MAX_PKT_LEN = 1'b0;
  localparam logic CFG_ACL_CHUNK   = 1'b1;

  // Configuration reset values.
  localparam logic [10:0] MAX_PKT_LEN_RST = 11'd1024;
  localparam logic [7:0]  ACL_CHUNK_RST   = 8'd255;

  // One outgoing result.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       channel;
    logic       chunk_end;
    logic       packet_end;
    logic       run_last;
  } result_t;

  // All results caused by one input byte (at most four header bytes).
  typedef struct packed {
    logic [2:0]       count;
    result_t [3:0]    res;
  } group_t;

  // Header length in bytes for each packet kind.
  function automatic logic [2:0] hdr_len(input kind_e kind);
    logic [2:0] len;
    unique case (kind)
      KIND_CMD: len = 3'd3;
      KIND_ACL: len = 3'd4;
      KIND_SCO: len = 3'd3;
      KIND_EVT: len = 3'd2;
      default:  len = 3'd2;
    endcase
    return len;
  endfunction

endpackage

### src/hcidf_ifs.sv
// Valid/ready channel interfaces for the H4 deframer: byte input and result output.
// Standalone; no package needed.
interface hcidf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       read_last;

  modport source (output valid, output rx_byte, output read_last, input ready);
  modport sink   (input valid, input rx_byte, input read_last, output ready);
endinterface

interface hcidf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       channel;
  logic       chunk_end;
  logic       packet_end;
  logic       run_last;

  modport source (output valid, output out_byte, output channel, output chunk_end,
                  output packet_end, output run_last, input ready);
  modport sink   (input valid, input out_byte, input channel, input chunk_end,
                  input packet_end, input run_last, output ready);
endinterface

### src/hcidf_core.sv
// Deframer core: per-byte framing state, configuration registers and result building.
// Depends on hcidf_pkg; feeds the result group of each accepted byte that yields results to the output queue.
module hcidf_core
  import hcidf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  logic        accept_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        read_last_i,
  output logic        push_o,
  output group_t      grp_o
);

  logic [10:0] max_len_q;
  logic [7:0]  chunk_size_q;
  logic [7:0]  hs_q [4];
  logic [2:0]  count_q, count_d;
  kind_e       kind_q, kind_d;
  logic        in_payload_q, in_payload_d;
  logic [10:0] left_q, left_d;
  logic [7:0]  fill_q, fill_d;
  logic        discard_q, discard_d;

  logic [7:0]  fill;
  logic [8:0]  cs;
  logic [15:0] len;
  logic [16:0] total;
  logic [10:0] left;
  logic [2:0]  hl;
  logic [1:0]  pos;
  logic        fwd, is_acl, done, pend, hs_we;
  group_t      grp;

  // One ACL submission step: returns {chunk end, new fill count}.
  function automatic logic [8:0] chunk_step(input logic [7:0] cur, input logic [7:0] size,
                                            input logic acl, input logic pkt_end);
    logic [7:0] nf;
    logic       ce;
    nf = cur;
    ce = pkt_end;
    if (acl) begin
      nf = cur + 8'd1;
      if (nf == size) ce = 1'b1;
      if (ce) nf = '0;
    end
    return {ce, nf};
  endfunction

  assign hl     = hdr_len(kind_q);
  assign fwd    = (kind_q == KIND_CMD) || (kind_q == KIND_ACL);
  assign is_acl = (kind_q == KIND_ACL);
  assign pos    = 2'(count_q - 3'd1);

  // Length from the header, with the byte now arriving as its last entry.
  assign len   = is_acl ? {rx_byte_i, hs_q[2]} : {8'd0, rx_byte_i};
  assign total = 17'd1 + {14'd0, hl} + {1'b0, len};

  // Framing state update and result construction for one byte.
  always_comb begin
    count_d      = count_q;
    kind_d       = kind_q;
    in_payload_d = in_payload_q;
    left_d       = left_q;
    fill_d       = fill_q;
    discard_d    = discard_q;
    grp          = '0;
    fill         = fill_q;
    cs           = '0;
    left         = left_q;
    done         = 1'b0;
    pend         = 1'b0;
    hs_we        = 1'b0;
    if (accept_i) begin
      if (discard_q) begin
        if (read_last_i) discard_d = 1'b0;
      end else if (in_payload_q) begin
        left   = left_q - {10'd0, (left_q != 11'd0)};
        left_d = left;
        done   = (left == 11'd0);
        if (fwd) begin
          cs     = chunk_step(fill_q, chunk_size_q, is_acl, done);
          fill_d = cs[7:0];
          grp.count = 3'd1;
          grp.res[0] = '{out_byte: rx_byte_i, channel: is_acl, chunk_end: cs[8],
                         packet_end: done, run_last: 1'b1};
        end
        if (done) begin
          in_payload_d = 1'b0;
          count_d      = '0;
        end
      end else if (count_q == 3'd0) begin
        if (rx_byte_i >= TYPE_FIRST && rx_byte_i <= TYPE_LAST) begin
          kind_d  = kind_e'(2'(rx_byte_i[1:0] - 2'd1));
          count_d = 3'd1;
        end else begin
          count_d      = '0;
          in_payload_d = 1'b0;
          left_d       = '0;
          discard_d    = !read_last_i;
        end
      end else begin
        hs_we   = 1'b1;
        count_d = count_q + 3'd1;
        if (count_q == hl) begin
          if (total > {6'd0, max_len_q}) begin
            // Oversized packet: drop the header and resync.
            count_d      = '0;
            in_payload_d = 1'b0;
            left_d       = '0;
            discard_d    = !read_last_i;
          end else begin
            if (fwd) begin
              grp.count = hl;
              for (int i = 0; i < 4; i++) begin
                if (3'(i) < hl) begin
                  pend = (3'(i) == hl - 3'd1) && (len == 16'd0);
                  cs   = chunk_step(fill, chunk_size_q, is_acl, pend);
                  fill = cs[7:0];
                  grp.res[2'(i)] = '{
                    out_byte:   (3'(i) == hl - 3'd1) ? rx_byte_i : hs_q[2'(i)],
                    channel:    is_acl,
                    chunk_end:  cs[8],
                    packet_end: pend,
                    run_last:   (3'(i) == hl - 3'd1)};
                end
              end
              fill_d = fill;
            end
            if (len == 16'd0) begin
              count_d = '0;
            end else begin
              left_d       = len[10:0];
              in_payload_d = 1'b1;
            end
          end
        end
      end
    end
  end

  assign push_o = accept_i && (grp.count != 3'd0);
  assign grp_o  = grp;

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q    <= MAX_PKT_LEN_RST;
      chunk_size_q <= ACL_CHUNK_RST;
      count_q      <= '0;
      kind_q       <= KIND_CMD;
      in_payload_q <= 1'b0;
      left_q       <= '0;
      fill_q       <= '0;
      discard_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_PKT_LEN: max_len_q    <= cfg_data_i;
          CFG_ACL_CHUNK:   chunk_size_q <= cfg_data_i[7:0];
          default:         max_len_q    <= max_len_q;
        endcase
      end
      count_q      <= count_d;
      kind_q       <= kind_d;
      in_payload_q <= in_payload_d;
      left_q       <= left_d;
      fill_q       <= fill_d;
      discard_q    <= discard_d;
    end
  end

  // Header byte store; an entry is read only after it was written for this packet.
  always_ff @(posedge clk_i) begin
    if (hs_we) hs_q[pos] <= rx_byte_i;
  end

endmodule

### src/hcidf_outq.sv
// Output group register: holds the results of one byte and hands them out one per cycle while tx_o is ready.
// Depends on hcidf_pkg, the channel interfaces and the assertion macro header.
`include "hci_uart_packet_deframer_top_assert.svh"

module hcidf_outq
  import hcidf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  group_t      grp_i,
  output logic        take_o,
  hcidf_out_if.source tx_o
);

  group_t     grp_q;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] ptr_q, ptr_d;
  logic       pop;
  result_t    cur;

  assign cur = grp_q.res[ptr_q];
  assign pop = tx_o.valid && tx_o.ready;

  // A new group may enter once the current one is gone or its last result leaves now.
  assign take_o = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && tx_o.ready);

  assign tx_o.valid      = (cnt_q != 3'd0);
  assign tx_o.out_byte   = cur.out_byte;
  assign tx_o.channel    = cur.channel;
  assign tx_o.chunk_end  = cur.chunk_end;
  assign tx_o.packet_end = cur.packet_end;
  assign tx_o.run_last   = cur.run_last;

  // Count and read pointer: advance on each transfer, reload on a new group.
  always_comb begin
    cnt_d = cnt_q;
    ptr_d = ptr_q;
    if (pop) begin
      cnt_d = cnt_q - 3'd1;
      ptr_d = ptr_q + 2'd1;
    end
    if (push_i) begin
      cnt_d = grp_i.count;
      ptr_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (push_i) grp_q <= grp_i;
  end

  // The pointer never runs past the results of the held group.
  `HCIDF_ASSERT(a_ptr_in_group, ({2'b0, ptr_q} + {1'b0, cnt_q}) <= 4'd4, "pointer past group")
  // A pushed group is shown in full from its first result.
  `HCIDF_ASSERT_NEXT(a_push_loads, push_i, (cnt_q == $past(grp_i.count)) && (ptr_q == 2'd0), "group not loaded")
  // The final result of a group closes the run of its input byte.
  `HCIDF_ASSERT(a_last_run, (tx_o.valid && cnt_q == 3'd1) |-> cur.run_last, "run_last missing")

endmodule

### src/hci_uart_packet_deframer_top.sv
// H4 HCI packet deframer, top level.
// Channels: rx_i takes one serial byte per transfer (rx_byte, read_last); tx_o
// gives one forwarded byte per transfer with its channel (0 command, 1 ACL),
// chunk_end, packet_end and run_last, which marks the last result of a byte.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 max_packet_len, 1 acl_chunk_size) at the clock edge; write only when idle.
// Output: the first result of a byte appears in the cycle after its transfer.
// Flow: the byte that completes a command or ACL header releases all of its header
// bytes (three or four) as results, which the single output register hands out
// one at a time; rx_i takes a new byte only when the last of them transfers.
// Payload bytes stream at one byte per cycle while tx_o is ready.
// Reset: rst_ni (asynchronous, active low) returns the framer to idle with
// no partial packet, clears discard mode and loads the configuration defaults.
// Stall: while tx_o is not ready, results are held, and rx_i.ready stays low
// unless the output register is empty or its last result transfers this cycle.
// Depends on hcidf_pkg, hcidf_ifs, hcidf_core and hcidf_outq.
module hci_uart_packet_deframer_top
  import hcidf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  hcidf_in_if.sink    rx_i,
  hcidf_out_if.source tx_o
);

  logic   take;
  logic   accept;
  logic   push;
  group_t grp;

  // Input transfer.
  assign rx_i.ready = take;
  assign accept     = rx_i.valid && take;

  hcidf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .rx_byte_i   (rx_i.rx_byte),
    .read_last_i (rx_i.read_last),
    .push_o      (push),
    .grp_o       (grp)
  );

  hcidf_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .grp_i  (grp),
    .take_o (take),
    .tx_o   (tx_o)
  );

endmodule
